### sv/mfd_pkg.sv
// Shared types, constants and helpers for the motor frame deframer.
// No dependencies; imported by every module of the block.
package mfd_pkg;

  localparam int unsigned FRAME_PAYLOAD_BYTES = 8;
  localparam int unsigned CHECKSUM_POSITION   = 8;
  localparam int unsigned POS_W               = 4;
  localparam int unsigned ONES_W              = 4;   // ones in one byte: 0..8
  localparam int unsigned TOTAL_W             = 7;   // ones in a payload: 0..64
  localparam int unsigned OUT_TDATA_W         = 72;  // 66 bits of fields, byte padded
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;
  localparam logic [7:0]  STOP_VALUE_RESET    = 8'hFF;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CHECK   = 2'd1,
    KIND_STOP    = 2'd2
  } byte_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SUM_ERR  = 2'd1,
    STATUS_STOP_ERR = 2'd2
  } frame_status_t;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    byte_kind_t         kind;
    logic [7:0]         data;
    logic [ONES_W-1:0]  ones;
    logic               stop_good;
  } qentry_t;

  function automatic logic [ONES_W-1:0] count_ones(input logic [7:0] v);
    logic [ONES_W-1:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + ONES_W'(v[k]);
    end
    return n;
  endfunction

endpackage

### sv/mfd_front.sv
// Front end: accepts received bytes, tracks frame position and stop hunting,
// tags each kept byte and pushes it into the queue. Depends on mfd_pkg.
module mfd_front import mfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  output logic       push,
  output qentry_t    push_entry,
  input  logic       q_full
);

  logic [7:0]       stop_value_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hunt_r, hunt_nxt;
  logic             accept;
  logic             stop_good;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign stop_good = (in_tdata == stop_value_r);

  always_comb begin
    pos_nxt              = pos_r;
    hunt_nxt             = hunt_r;
    push                 = 1'b0;
    push_entry.kind      = KIND_PAYLOAD;
    push_entry.data      = in_tdata;
    push_entry.ones      = count_ones(in_tdata);
    push_entry.stop_good = stop_good;
    if (accept) begin
      if (hunt_r) begin
        // discard until the terminator, then realign
        if (stop_good) begin
          hunt_nxt = 1'b0;
          pos_nxt  = '0;
        end
      end else if (pos_r < POS_W'(FRAME_PAYLOAD_BYTES)) begin
        push    = 1'b1;
        pos_nxt = pos_r + 1'b1;
      end else if (pos_r == POS_W'(CHECKSUM_POSITION)) begin
        push            = 1'b1;
        push_entry.kind = KIND_CHECK;
        pos_nxt         = pos_r + 1'b1;
      end else begin
        push            = 1'b1;
        push_entry.kind = KIND_STOP;
        pos_nxt         = '0;
        hunt_nxt        = !stop_good;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_value_r <= STOP_VALUE_RESET;
      pos_r        <= '0;
      hunt_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stop_value_r <= cfg_wr_data;
      end
      pos_r  <= pos_nxt;
      hunt_r <= hunt_nxt;
    end
  end

  a_hunt_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    hunt_r |-> !push)
    else $error("byte pushed while hunting for stop");

endmodule

### sv/mfd_queue.sv
// Short FIFO of classified bytes between front and back.
// Depends on mfd_pkg for the entry type.
module mfd_queue import mfd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_entry,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output qentry_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  qentry_t       slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

### sv/mfd_back.sv
// Back end: drains the queue, assembles payload, checksum match and status,
// and holds the finished frame in the output register. Depends on mfd_pkg.
module mfd_back import mfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  qentry_t                head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [63:0]            payload_r;
  logic [TOTAL_W-1:0]     ones_r;
  logic                   match_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_free;
  logic                   load;
  frame_status_t          status;

  assign out_free = !out_valid_r || out_tready;
  assign pop      = !q_empty && ((head.kind != KIND_STOP) || out_free);
  assign load     = pop && (head.kind == KIND_STOP);

  assign status = !head.stop_good ? STATUS_STOP_ERR :
                  (match_r ? STATUS_OK : STATUS_SUM_ERR);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head.kind)
        KIND_PAYLOAD: payload_r <= {payload_r[55:0], head.data};
        default: ;
      endcase
    end
    if (load) begin
      // status, flags, third, second, first from the top down
      out_data_r <= {6'd0, status, payload_r[15:0], payload_r[31:16],
                     payload_r[47:32], payload_r[63:48]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_r      <= '0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        case (head.kind)
          KIND_PAYLOAD: ones_r  <= ones_r + TOTAL_W'(head.ones);
          KIND_CHECK:   match_r <= ({1'b0, ones_r} == head.data);
          KIND_STOP: begin
            ones_r  <= '0;
            match_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (ones_r == '0) && out_valid_r)
    else $error("frame end did not clear count or raise valid");

endmodule

### sv/motor_frame_deframer_core.sv
// Top level of the motor frame deframer: front classifier, byte queue and
// frame assembler. Depends on mfd_pkg, mfd_front, mfd_queue, mfd_back.
//
// Usage:
//   in_*  : one received serial byte per item (in_tdata[7:0] = rx_byte).
//   out_* : one item per ten-byte frame, carrying the three big-endian
//           signed motor values, the flag word and a status
//           (ok, checksum mismatch, bad stop byte; bad stop wins).
//   cfg_* : cfg_wr_en high at a clock edge loads cfg_wr_data as the
//           expected stop byte. Write only while the block is idle.
// A frame is bytes 0..7 payload, byte 8 checksum (ones count of the
// payload), byte 9 stop. After a bad stop byte, bytes are dropped until
// one equals the stop value; the next byte then starts a new frame.
// Throughput: one byte per cycle while the queue has room. The front tags
// each byte as it is accepted; the back drains one tagged byte per cycle
// from the queue, but holds a stop byte while the output register is busy.
// A stop byte is queued first, then its frame loads the output register.
// Stall: while out_tready is low the finished frame holds in the output
// register; the back keeps absorbing payload bytes of the next frame and
// only waits at its stop byte, so in_tready drops once the queue fills.
// Reset (rst_n low, synchronous): queue empty, framing aligned to byte 0,
// no result pending, stop value back to 0xFF.
module motor_frame_deframer_core import mfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,  // stop_value
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,     // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] motor_first, [31:16] motor_second, [47:32] motor_third,
  // [63:48] flag_bits, [65:64] frame_status, [71:66] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic    push, q_full, q_empty, pop;
  qentry_t push_entry, head;

  mfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  mfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  mfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
